@@ rtl/csfb_pkg.sv @@
// ----------------------------------------------------------------------------
// csfb_pkg
// Shared widths, defaults, control types and helpers for the sample filter bank.
// ----------------------------------------------------------------------------
`default_nettype none

package csfb_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int ALPHA_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int ACC_W    = SAMPLE_W + FRAC_W;
    localparam int OS_W     = 16;

    // default smoothing factor, 0.15 in Q0.16
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd9830;

    // default depths and shift
    localparam int AVG_DEPTH_DEF        = 16;
    localparam int OVERSAMPLE_DEPTH_DEF = 256;
    localparam int OVERSAMPLE_SHIFT_DEF = 4;

    // read issue and update strobes for a window memory
    typedef struct packed {
        logic rd;   // issue read of the current slot
        logic upd;  // write back and update the running totals
    } t_win_ctrl;

    // middle value of three samples
    function automatic logic [SAMPLE_W-1:0] mid3(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] c
    );
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] hc;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        hc = (hi < c) ? hi : c;
        return (lo > hc) ? lo : hc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cascaded_sample_filter_bank_top.sv @@
// ----------------------------------------------------------------------------
// cascaded_sample_filter_bank_top
// Median, exponential, moving average and oversampling filters on one stream.
// ----------------------------------------------------------------------------
// One 12-bit sample goes in per transfer and one result of six filtered values
// comes out per transfer, in order. The block takes a new sample every clock
// cycle while the output is not backed up and the clearing pass is done; the
// rate is set by the read and write back of the two window memories (the moving
// average ring and the oversampling ring), each read on the input transfer and
// written back as the sample leaves stage one. A result passes through the
// stage one registers and then the output register. After reset a clearing
// pass writes zeros through both rings; no sample is taken in that time, but
// alpha writes are. Write alpha only while no sample is in flight.
`default_nettype none

module cascaded_sample_filter_bank_top
    import csfb_pkg::*;
#(
    parameter int AVG_DEPTH        = AVG_DEPTH_DEF,
    parameter int OVERSAMPLE_DEPTH = OVERSAMPLE_DEPTH_DEF,
    parameter int OVERSAMPLE_SHIFT = OVERSAMPLE_SHIFT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // alpha_q16 write channel
    input  wire logic               i_cfg_valid,
    input  wire logic [ALPHA_W-1:0] i_cfg_data,
    output logic                    o_cfg_ready,
    // sample input
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [15:0]        s_axis_tdata,   // raw_sample[11:0], zero pad
    // result output
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [79:0]             m_axis_tdata    // median_out, ema_raw_out,
                                                    // ema_median_out, avg_raw_out,
                                                    // avg_median_out,
                                                    // oversampled_out, zero pad
);

    localparam int AVG_L    = $clog2(AVG_DEPTH);
    localparam int AVG_N    = SAMPLE_W + AVG_L;
    localparam int AVG_PW   = 2 * AVG_N + 1;
    localparam logic [63:0] AVG_RECIP_64 =
        ((64'd1 << (AVG_N + AVG_L)) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
    localparam logic [AVG_N:0] AVG_RECIP = AVG_RECIP_64[AVG_N:0];
    localparam int OS_TOT_W = SAMPLE_W + $clog2(OVERSAMPLE_DEPTH);
    localparam int OS_EXT_W = OS_TOT_W + OS_W;
    localparam int DATA_W   = 5 * SAMPLE_W + OS_W;

    logic [ALPHA_W-1:0]              r_alpha;
    logic [SAMPLE_W-1:0]             r_prev1;
    logic [SAMPLE_W-1:0]             r_prev2;
    logic                            r_s1_vld;
    logic [SAMPLE_W-1:0]             r_s1_x;
    logic [SAMPLE_W-1:0]             r_s1_med;
    logic                            r_out_vld;
    logic [DATA_W-1:0]               r_out_data;

    logic                            w_in_xfer;
    logic                            w_out_free;
    logic                            w_s1_adv;
    logic [SAMPLE_W-1:0]             w_x;
    logic [SAMPLE_W-1:0]             w_med;
    t_win_ctrl                       w_ctrl;
    logic                            w_avg_ready;
    logic                            w_os_ready;
    logic [1:0][SAMPLE_W-1:0]        w_avg_in;
    logic [1:0][AVG_N-1:0]           w_avg_tot;
    logic [0:0][SAMPLE_W-1:0]        w_os_in;
    logic [0:0][OS_TOT_W-1:0]        w_os_tot;
    logic [SAMPLE_W-1:0]             w_ema_raw;
    logic [SAMPLE_W-1:0]             w_ema_med;
    logic [AVG_PW-1:0]               w_avg_raw_prod;
    logic [AVG_PW-1:0]               w_avg_med_prod;
    logic [OS_EXT_W-1:0]             w_os_ext;
    logic [OS_W-1:0]                 w_os;

    // handshakes
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_s1_adv      = r_s1_vld && w_out_free;
    assign s_axis_tready = w_avg_ready && w_os_ready && (!r_s1_vld || w_s1_adv);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(80 - DATA_W){1'b0}}, r_out_data};

    // median of the new sample and the two before it
    assign w_x   = s_axis_tdata[SAMPLE_W-1:0];
    assign w_med = mid3(w_x, r_prev1, r_prev2);

    // alpha register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_valid) begin
            r_alpha <= i_cfg_data;
        end
    end

    // median history and first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev1  <= '0;
            r_prev2  <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_prev1  <= w_x;
                r_prev2  <= r_prev1;
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_x   <= w_x;
            r_s1_med <= w_med;
        end
    end

    // window memories: read on input transfer, write back as stage one leaves
    assign w_ctrl.rd  = w_in_xfer;
    assign w_ctrl.upd = w_s1_adv;
    assign w_avg_in   = {r_s1_med, r_s1_x};
    assign w_os_in    = r_s1_x;

    csfb_window #(
        .DEPTH (AVG_DEPTH),
        .LANES (2)
    ) u_avg_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_x         (w_avg_in),
        .o_total_nxt (w_avg_tot),
        .o_ready     (w_avg_ready)
    );

    csfb_window #(
        .DEPTH (OVERSAMPLE_DEPTH),
        .LANES (1)
    ) u_os_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_x         (w_os_in),
        .o_total_nxt (w_os_tot),
        .o_ready     (w_os_ready)
    );

    // exponential averages
    csfb_ema u_ema_raw (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_s1_adv),
        .i_alpha   (r_alpha),
        .i_x       (r_s1_x),
        .o_int_nxt (w_ema_raw)
    );

    csfb_ema u_ema_med (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_s1_adv),
        .i_alpha   (r_alpha),
        .i_x       (r_s1_med),
        .o_int_nxt (w_ema_med)
    );

    // floor division of the moving sums by reciprocal multiply
    assign w_avg_raw_prod = AVG_PW'(w_avg_tot[0]) * AVG_PW'(AVG_RECIP);
    assign w_avg_med_prod = AVG_PW'(w_avg_tot[1]) * AVG_PW'(AVG_RECIP);

    // oversampled value, saturated to the field width
    assign w_os_ext = OS_EXT_W'(w_os_tot[0] >> OVERSAMPLE_SHIFT);
    assign w_os     = (w_os_ext > OS_EXT_W'({OS_W{1'b1}})) ? {OS_W{1'b1}} : w_os_ext[OS_W-1:0];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= {w_os,
                           w_avg_med_prod[AVG_N + AVG_L +: SAMPLE_W],
                           w_avg_raw_prod[AVG_N + AVG_L +: SAMPLE_W],
                           w_ema_med,
                           w_ema_raw,
                           r_s1_med};
        end
    end

endmodule

`default_nettype wire

@@ rtl/csfb_ema.sv @@
// ----------------------------------------------------------------------------
// csfb_ema
// Exponential average in Q12.16, one update per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csfb_ema
    import csfb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic [ALPHA_W-1:0]  i_alpha,
    input  wire logic [SAMPLE_W-1:0] i_x,
    output logic      [SAMPLE_W-1:0] o_int_nxt
);

    localparam int PROD_W = ALPHA_W + ACC_W;

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [ACC_W-1:0]  w_target;
    logic              w_up;
    logic [ACC_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W:0]   w_dec_sum;
    logic [ACC_W-1:0]  w_inc;
    logic [ACC_W-1:0]  w_dec;

    // distance to target, scaled by alpha
    assign w_target = {i_x, {FRAC_W{1'b0}}};
    assign w_up     = (w_target >= r_acc);
    assign w_mag    = w_up ? (w_target - r_acc) : (r_acc - w_target);
    assign w_prod   = PROD_W'(i_alpha) * PROD_W'(w_mag);

    // floor toward minus infinity: round the decrement up
    assign w_dec_sum = {1'b0, w_prod} + (PROD_W + 1)'({FRAC_W{1'b1}});
    assign w_inc     = w_prod[FRAC_W +: ACC_W];
    assign w_dec     = w_dec_sum[FRAC_W +: ACC_W];

    assign n_acc     = w_up ? (r_acc + w_inc) : (r_acc - w_dec);
    assign o_int_nxt = n_acc[FRAC_W +: SAMPLE_W];

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

@@ rtl/csfb_window.sv @@
// ----------------------------------------------------------------------------
// csfb_window
// Ring memory of past samples with running totals, one or more lanes per word.
// ----------------------------------------------------------------------------
`default_nettype none

module csfb_window
    import csfb_pkg::*;
#(
    parameter int DEPTH = AVG_DEPTH_DEF,
    parameter int LANES = 1
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire t_win_ctrl                                         i_ctrl,
    input  wire logic [LANES-1:0][SAMPLE_W-1:0]                    i_x,
    output logic      [LANES-1:0][SAMPLE_W+$clog2(DEPTH)-1:0]      o_total_nxt,
    output logic                                                   o_ready
);

    localparam int AW    = $clog2(DEPTH);
    localparam int TOT_W = SAMPLE_W + AW;
    localparam int WORD  = LANES * SAMPLE_W;

    logic [WORD-1:0]                 r_mem [DEPTH];
    logic [LANES-1:0][SAMPLE_W-1:0]  r_rd_data;
    logic [AW-1:0]                   r_slot;
    logic [AW-1:0]                   r_wr_slot;
    logic [AW-1:0]                   r_clr_addr;
    logic                            r_clr_busy;
    logic [LANES-1:0][TOT_W-1:0]     r_total;
    logic [LANES-1:0][TOT_W-1:0]     n_total;
    logic                            w_we;
    logic [AW-1:0]                   w_wa;
    logic [WORD-1:0]                 w_wd;

    // running totals: drop the oldest sample, add the new one
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_total[l] = r_total[l] - TOT_W'(r_rd_data[l]) + TOT_W'(i_x[l]);
        end
    end

    assign o_total_nxt = n_total;
    assign o_ready     = !r_clr_busy;

    // single write port: clearing pass or write back
    assign w_we = r_clr_busy || i_ctrl.upd;
    assign w_wa = r_clr_busy ? r_clr_addr : r_wr_slot;
    assign w_wd = r_clr_busy ? '0 : WORD'(i_x);

    // sample memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_ctrl.rd) begin
            r_rd_data <= r_mem[r_slot];
        end
    end

    // slot pointers, clearing pass and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_wr_slot  <= '0;
            r_clr_addr <= '0;
            r_clr_busy <= 1'b1;
            r_total    <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_ctrl.rd) begin
                r_wr_slot <= r_slot;
                r_slot    <= (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + AW'(1);
            end
            if (i_ctrl.upd) begin
                r_total <= n_total;
            end
        end
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cascaded sample filter bank. A driver offers ADC
// samples from a queue and a monitor predicts the six filtered values for each
// accepted sample. The same monitor compares every result transfer against the
// oldest prediction, one field at a time. Phases change alpha while the block
// is idle. Both stream sides idle in random bursts, and one long receive
// hold-off makes the block back up and stall its input.
// ----------------------------------------------------------------------------
module testbench;
    import csfb_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 20;
    localparam int REPORT_LIMIT    = 100;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

    // one result transfer, lowest field in the lowest bits
    typedef struct packed {
        logic [3:0]          pad;
        logic [OS_W-1:0]     oversampled;
        logic [SAMPLE_W-1:0] avg_median;
        logic [SAMPLE_W-1:0] avg_raw;
        logic [SAMPLE_W-1:0] ema_median;
        logic [SAMPLE_W-1:0] ema_raw;
        logic [SAMPLE_W-1:0] median;
    } t_filt_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [ALPHA_W-1:0] i_cfg_data = '0;
    logic               o_cfg_ready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;   // raw_sample[11:0], zero pad
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [79:0]        m_axis_tdata;        // median_out, ema_raw_out,
                                             // ema_median_out, avg_raw_out,
                                             // avg_median_out,
                                             // oversampled_out, zero pad

    cascaded_sample_filter_bank_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and scoreboard storage
    logic [15:0]  sample_q [$];
    t_filt_result filtered_q [$];
    int           mismatches = 0;
    int           cycle_cnt = 0;
    bit           in_fire = 1'b0;
    bit           idle_on = 1'b1;
    bit           hold_req = 1'b0;
    int           hold_left = 0;
    int           src_gap = 0;
    int           sink_gap = 0;

    // predicted filter state
    logic [ALPHA_W-1:0]  alpha_model;
    logic [SAMPLE_W-1:0] med_hist [3];
    int unsigned         med_pos;
    logic [ACC_W-1:0]    ema_raw_q;
    logic [ACC_W-1:0]    ema_med_q;
    logic [SAMPLE_W-1:0] raw_ring [AVG_DEPTH_DEF];
    logic [SAMPLE_W-1:0] med_ring [AVG_DEPTH_DEF];
    int unsigned         ring_pos;
    logic [15:0]         raw_sum;
    logic [15:0]         med_sum;
    logic [SAMPLE_W-1:0] os_ring [OVERSAMPLE_DEPTH_DEF];
    int unsigned         os_pos;
    logic [19:0]         os_sum;

    function automatic logic [SAMPLE_W-1:0] middle_of(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] c
    );
        if ((a >= b && a <= c) || (a <= b && a >= c))
            return a;
        if ((b >= a && b <= c) || (b <= a && b >= c))
            return b;
        return c;
    endfunction

    // q12.16 exponential average step, decrements rounded up so the result floors
    function automatic logic [ACC_W-1:0] ema_next(
        input logic [ACC_W-1:0]    acc,
        input logic [SAMPLE_W-1:0] x
    );
        logic [ACC_W-1:0]         target;
        logic [ACC_W-1:0]         diff;
        logic [ACC_W+ALPHA_W-1:0] scaled;
        target = {x, {FRAC_W{1'b0}}};
        if (target >= acc) begin
            diff   = target - acc;
            scaled = (ACC_W+ALPHA_W)'(alpha_model) * (ACC_W+ALPHA_W)'(diff);
            return acc + scaled[ACC_W+ALPHA_W-1:FRAC_W];
        end else begin
            diff   = acc - target;
            scaled = (ACC_W+ALPHA_W)'(alpha_model) * (ACC_W+ALPHA_W)'(diff)
                   + (ACC_W+ALPHA_W)'({FRAC_W{1'b1}});
            return acc - scaled[ACC_W+ALPHA_W-1:FRAC_W];
        end
    endfunction

    // advance all filters by one sample and form the expected result
    function automatic t_filt_result filter_bank_step(input logic [SAMPLE_W-1:0] x);
        t_filt_result        r;
        logic [SAMPLE_W-1:0] med;
        logic [19:0]         os_scaled;
        med_hist[med_pos] = x;
        med_pos = (med_pos == 2) ? 0 : med_pos + 1;
        med = middle_of(med_hist[0], med_hist[1], med_hist[2]);

        ema_raw_q = ema_next(ema_raw_q, x);
        ema_med_q = ema_next(ema_med_q, med);

        raw_sum = raw_sum - 16'(raw_ring[ring_pos]) + 16'(x);
        med_sum = med_sum - 16'(med_ring[ring_pos]) + 16'(med);
        raw_ring[ring_pos] = x;
        med_ring[ring_pos] = med;
        ring_pos = (ring_pos + 1 >= AVG_DEPTH_DEF) ? 0 : ring_pos + 1;

        os_sum = os_sum - 20'(os_ring[os_pos]) + 20'(x);
        os_ring[os_pos] = x;
        os_pos = (os_pos + 1 >= OVERSAMPLE_DEPTH_DEF) ? 0 : os_pos + 1;
        os_scaled = os_sum >> OVERSAMPLE_SHIFT_DEF;

        r.pad         = '0;
        r.oversampled = (os_scaled > 20'hFFFF) ? 16'hFFFF : os_scaled[15:0];
        r.avg_median  = SAMPLE_W'(med_sum / AVG_DEPTH_DEF);
        r.avg_raw     = SAMPLE_W'(raw_sum / AVG_DEPTH_DEF);
        r.ema_median  = ema_med_q[ACC_W-1:FRAC_W];
        r.ema_raw     = ema_raw_q[ACC_W-1:FRAC_W];
        r.median      = med;
        return r;
    endfunction

    task automatic check_field(
        input string           label,
        input logic [OS_W-1:0] want,
        input logic [OS_W-1:0] got
    );
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, label, want, got);
        end
    endtask

    // accepted samples feed the predictor, result transfers are checked
    always @(posedge i_clk) begin
        t_filt_result want;
        t_filt_result got;
        in_fire = s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                alpha_model = i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, m_axis_tdata);
                end else begin
                    want = filtered_q.pop_front();
                    check_field("median_out", OS_W'(want.median), OS_W'(got.median));
                    check_field("ema_raw_out", OS_W'(want.ema_raw), OS_W'(got.ema_raw));
                    check_field("ema_median_out", OS_W'(want.ema_median),
                                OS_W'(got.ema_median));
                    check_field("avg_raw_out", OS_W'(want.avg_raw), OS_W'(got.avg_raw));
                    check_field("avg_median_out", OS_W'(want.avg_median),
                                OS_W'(got.avg_median));
                    check_field("oversampled_out", want.oversampled, got.oversampled);
                    check_field("pad", OS_W'(want.pad), OS_W'(got.pad));
                end
            end
            if (in_fire)
                filtered_q.push_back(filter_bank_step(s_axis_tdata[SAMPLE_W-1:0]));
        end
    end

    // sample driver, holds each offered sample until its transfer
    always @(negedge i_clk) begin
        if (s_axis_tvalid && !in_fire) begin
            // keep offering the same sample
        end else if (src_gap > 0) begin
            src_gap--;
            s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
            s_axis_tdata  <= sample_q.pop_front();
            s_axis_tvalid <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0)
                src_gap = $urandom_range(1, 13);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // result sink with random stall bursts and one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            sink_gap = $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // random pad bits above the sample field now and then
    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        logic [3:0] pad;
        pad = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h0;
        sample_q.push_back({pad, s});
    endtask

    // mix of uniform noise, rail hits, level steps and a noisy level
    task automatic queue_samples(input int count);
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] s;
        int                  v;
        level = SAMPLE_W'($urandom_range(0, FULL_SCALE));
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0, 1: s = SAMPLE_W'($urandom_range(0, FULL_SCALE));
                2: s = $urandom_range(0, 1) ? FULL_SCALE : '0;
                3: begin
                    level = SAMPLE_W'($urandom_range(0, FULL_SCALE));
                    s = level;
                end
                default: begin
                    v = int'(level) + int'($urandom_range(0, 64)) - 32;
                    if (v < 0)
                        v = 0;
                    if (v > int'(FULL_SCALE))
                        v = int'(FULL_SCALE);
                    s = SAMPLE_W'(v);
                end
            endcase
            push_sample(s);
        end
    endtask

    // sender pause until every expected result has come back
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || filtered_q.size() != 0);
    endtask

    task automatic write_alpha(input logic [ALPHA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        // predictor starts from the reset state
        alpha_model = ALPHA_RESET;
        med_pos = 0;
        ring_pos = 0;
        os_pos = 0;
        ema_raw_q = '0;
        ema_med_q = '0;
        raw_sum = '0;
        med_sum = '0;
        os_sum = '0;
        foreach (med_hist[k])
            med_hist[k] = '0;
        foreach (raw_ring[k])
            raw_ring[k] = '0;
        foreach (med_ring[k])
            med_ring[k] = '0;
        foreach (os_ring[k])
            os_ring[k] = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rails, median ties, walking ones, patterns, wide input
        push_sample('0);
        push_sample(FULL_SCALE);
        push_sample('0);
        push_sample(FULL_SCALE);
        push_sample(FULL_SCALE);
        push_sample('0);
        for (int k = 0; k < SAMPLE_W; k++)
            push_sample(SAMPLE_W'(1) << k);
        push_sample(12'hAAA);
        push_sample(12'h555);
        push_sample(12'h7FF);
        push_sample(12'h800);
        push_sample(12'h123);
        push_sample(12'h123);
        sample_q.push_back({4'hF, 12'h123});
        wait_drained();

        // fastest averaging
        write_alpha(16'hFFFF);
        queue_samples(200);
        wait_drained();

        // frozen averages, no idling on either side
        idle_on = 1'b0;
        write_alpha(16'h0000);
        queue_samples(100);
        wait_drained();

        // slowest nonzero alpha under a long receive hold-off
        idle_on = 1'b1;
        write_alpha(16'h0001);
        queue_samples(150);
        hold_req = 1'b1;
        wait_drained();

        // full-scale run fills the oversampling window
        write_alpha(16'h8000);
        for (int k = 0; k < 270; k++)
            push_sample(FULL_SCALE);
        queue_samples(30);
        wait_drained();

        write_alpha(ALPHA_W'($urandom_range(0, 65535)));
        queue_samples(300);
        wait_drained();

        // closing stretch at the default alpha without idling
        idle_on = 1'b0;
        write_alpha(ALPHA_RESET);
        queue_samples(375);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ cascaded_sample_filter_bank_top.f @@
rtl/csfb_pkg.sv
rtl/csfb_ema.sv
rtl/csfb_window.sv
rtl/cascaded_sample_filter_bank_top.sv
verif/testbench.sv
